@@ sv/zero_lag_ema_filter_core_assert.svh @@
// Assertion macros for the zero-lag EMA filter.
`ifndef ZERO_LAG_EMA_FILTER_CORE_ASSERT_SVH
`define ZERO_LAG_EMA_FILTER_CORE_ASSERT_SVH

`ifndef ASSERT_OFF
// Same-cycle implication.
`define ZLEMA_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("zlema: implication check failed");
// Next-cycle implication.
`define ZLEMA_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("zlema: next-cycle check failed");
`else
`define ZLEMA_ASSERT_IMP(label, clk, rstn, ante, cons)
`define ZLEMA_ASSERT_NXT(label, clk, rstn, ante, cons)
`endif

`endif

@@ sv/zlema_pkg.sv @@
package zlema_pkg;

    localparam int DEF_MAX_PERIOD  = 64;
    localparam int DEF_DELAY_DEPTH = 32;

    localparam int SAMPLE_W   = 32;
    localparam int MEM_W      = SAMPLE_W + 1;
    localparam int Z_W        = 34;
    localparam int AVG_W      = 34;
    localparam int EMA_W      = 50;
    localparam int FRAC_W     = 16;
    localparam int SEED_W     = 42;
    localparam int SEED_CNT_W = 7;
    localparam int CNT_W      = 8;
    localparam int PERIOD_W   = 7;
    localparam int ALPHA_W    = 17;
    localparam int DIV_W      = 60;
    localparam int DIVISOR_W  = SEED_CNT_W + 1;
    localparam int MUL_A_W    = ALPHA_W + 1;
    localparam int MUL_B_W    = Z_W + 1;
    localparam int PROD_W     = MUL_A_W + MUL_B_W;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = ALPHA_W;

    localparam logic [CFG_IDX_W-1:0] CFG_PERIOD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA  = 2'd1;

    localparam logic [PERIOD_W-1:0] PERIOD_RESET = 7'd30;
    localparam logic [ALPHA_W-1:0]  ALPHA_RESET  = 17'd4228;
    localparam logic [ALPHA_W-1:0]  Q_ONE        = 17'd65536;
    localparam int                  Q_HALF       = 32768;
    localparam logic [CNT_W-1:0]    CNT_MAX      = 8'd255;

endpackage

@@ sv/zero_lag_ema_filter_core.sv @@
// Zero-lag EMA filter. Each input word carries one sample and a present flag;
// each input word yields exactly one output word, in order. Past samples sit in
// a circular buffer RAM of DELAY_DEPTH entries with a registered read; the
// de-lagged value 2x - x[n-lag] is formed from the RAM read, and the EMA update
// runs three products through one shared 18x35 multiplier. In steady state an
// item passes S_READ, S_EVAL, S_MUL_BHI, S_MUL_BLO, S_UPDATE and S_OUT; during
// warm-up it goes from S_EVAL straight to S_OUT, and the item that seeds the EMA
// waits on a one-bit-per-cycle 60-step divider forming the seed mean. A new word
// is accepted only when the previous item has moved to the output register; a
// full output register holds the next result back. No clearing pass is needed
// after reset or a period write: a sample count gates RAM entries not yet
// written. Registers: index 0 is period (write clears all filter state), index
// 1 is alpha in Q1.16.
`include "zero_lag_ema_filter_core_assert.svh"

module zero_lag_ema_filter_core
    import zlema_pkg::*;
#(
    parameter int MAX_PERIOD  = DEF_MAX_PERIOD,
    parameter int DELAY_DEPTH = DEF_DELAY_DEPTH
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic signed [SAMPLE_W-1:0] s_sample,
    input  logic                    s_sample_valid,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic signed [AVG_W-1:0] m_average,
    output logic                    m_average_valid,
    input  logic                    cfg_we,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [CFG_DATA_W-1:0]   cfg_wdata
);

    localparam int ADDR_W = (DELAY_DEPTH > 1) ? $clog2(DELAY_DEPTH) : 1;
    localparam logic [8:0] MAXP_9  = 9'(MAX_PERIOD);
    localparam logic [8:0] DEPTH_9 = 9'(DELAY_DEPTH);
    localparam logic signed [PROD_W-1:0] ROUND_HALF = PROD_W'(Q_HALF);
    localparam logic signed [EMA_W:0]    AVG_HALF   = (EMA_W + 1)'(Q_HALF);

    typedef enum logic [3:0] {
        S_IDLE, S_READ, S_EVAL, S_DIV_GO, S_DIV_WAIT,
        S_MUL_BHI, S_MUL_BLO, S_UPDATE, S_OUT
    } state_t;

    state_t                        state_reg;
    logic [PERIOD_W-1:0]           period_reg;
    logic [ALPHA_W-1:0]            alpha_reg;
    logic signed [SAMPLE_W-1:0]    x_reg;
    logic                          xv_reg;
    logic signed [Z_W-1:0]         z_reg;
    logic                          zv_reg;
    logic [CNT_W-1:0]              cnt_reg;
    logic [ADDR_W-1:0]             wp_reg;
    logic signed [SEED_W-1:0]      seed_sum_reg;
    logic [SEED_CNT_W-1:0]         seed_cnt_reg;
    logic signed [EMA_W-1:0]       ema_reg;
    logic                          ema_def_reg;
    logic                          avg_ok_reg;
    logic signed [PROD_W-1:0]      prod_reg;
    logic signed [PROD_W-1:0]      acc_reg;
    logic                          m_valid_reg;
    logic signed [AVG_W-1:0]       m_average_reg;
    logic                          m_average_valid_reg;

    logic [PERIOD_W-1:0]           p_eff;
    logic [PERIOD_W-1:0]           p_less;
    logic [CNT_W-1:0]              lag_raw;
    logic [CNT_W-1:0]              lag_8;
    logic [CNT_W-1:0]              seed_at;
    logic                          lag_zero;
    logic [ALPHA_W-1:0]            alpha_sat;
    logic [ALPHA_W-1:0]            beta;

    logic [8:0]                    wp_9;
    logic [8:0]                    lag_9;
    logic [8:0]                    rd_sum;
    logic [ADDR_W-1:0]             rd_addr;
    logic                          rd_en;
    logic                          wr_en;
    logic [MEM_W-1:0]              rd_data;
    logic signed [SAMPLE_W-1:0]    d_sample;
    logic                          d_valid;

    logic signed [Z_W-1:0]         z_calc;
    logic                          zv_calc;
    logic signed [SEED_W-1:0]      seed_add;
    logic signed [SEED_W-1:0]      sum_after;
    logic [SEED_CNT_W-1:0]         cnt_after;
    logic [CNT_W-1:0]              cnt_inc;

    logic signed [MUL_A_W-1:0]     op_a;
    logic signed [MUL_B_W-1:0]     op_b;
    logic signed [PROD_W-1:0]      mul_out;
    logic signed [PROD_W-1:0]      blo_rnd;
    logic signed [PROD_W-1:0]      acc_upd;
    logic signed [EMA_W:0]         avg_sum;

    logic                          div_start;
    logic signed [DIV_W-1:0]       div_numer;
    logic [DIVISOR_W-1:0]          div_denom;
    logic                          div_done;
    logic signed [EMA_W-1:0]       div_quot;

    // period clamps to 1..MAX_PERIOD, lag clamps to the buffer depth
    assign p_eff   = (period_reg == '0) ? PERIOD_W'(1) :
                     ({2'b00, period_reg} > MAXP_9) ? MAXP_9[PERIOD_W-1:0] : period_reg;
    assign p_less  = p_eff - 1'b1;
    assign lag_raw = CNT_W'(p_less[PERIOD_W-1:1]);
    assign lag_8   = ({1'b0, lag_raw} > DEPTH_9) ? DEPTH_9[CNT_W-1:0] : lag_raw;
    assign seed_at = CNT_W'(p_eff) + lag_8 - 1'b1;
    assign lag_zero = (lag_8 == '0);

    assign alpha_sat = (alpha_reg > Q_ONE) ? Q_ONE : alpha_reg;
    assign beta      = Q_ONE - alpha_sat;

    // read the sample written lag words ago
    assign wp_9    = 9'(wp_reg);
    assign lag_9   = {1'b0, lag_8};
    assign rd_sum  = (wp_9 >= lag_9) ? (wp_9 - lag_9) : (wp_9 + DEPTH_9 - lag_9);
    assign rd_addr = rd_sum[ADDR_W-1:0];
    assign rd_en   = s_valid && s_ready;
    assign wr_en   = (state_reg == S_READ);

    zlema_delay_mem #(
        .DEPTH (DELAY_DEPTH)
    ) u_delay_mem (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wp_reg),
        .wr_data ({xv_reg, x_reg}),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign d_sample = rd_data[SAMPLE_W-1:0];
    assign d_valid  = rd_data[SAMPLE_W];

    assign z_calc  = lag_zero ? Z_W'(x_reg) :
                     ({x_reg[SAMPLE_W-1], x_reg, 1'b0} - Z_W'(d_sample));
    assign zv_calc = lag_zero ? xv_reg : (xv_reg && d_valid && (cnt_reg >= lag_8));

    assign seed_add  = zv_reg ? SEED_W'(z_reg) : '0;
    assign sum_after = seed_sum_reg + seed_add;
    assign cnt_after = seed_cnt_reg + SEED_CNT_W'(zv_reg);
    assign cnt_inc   = (cnt_reg == CNT_MAX) ? cnt_reg : cnt_reg + 1'b1;

    // shared multiplier: alpha*z, then beta*hi, then beta*lo
    always_comb begin
        case (state_reg)
            S_MUL_BHI: begin
                op_a = {1'b0, beta};
                op_b = MUL_B_W'($signed(ema_reg[EMA_W-1:FRAC_W]));
            end
            S_MUL_BLO: begin
                op_a = {1'b0, beta};
                op_b = {{(MUL_B_W - FRAC_W){1'b0}}, ema_reg[FRAC_W-1:0]};
            end
            default: begin
                op_a = {1'b0, alpha_sat};
                op_b = MUL_B_W'(z_reg);
            end
        endcase
    end

    assign mul_out = op_a * op_b;
    assign blo_rnd = (prod_reg + ROUND_HALF) >>> FRAC_W;
    assign acc_upd = acc_reg + blo_rnd;
    assign avg_sum = (EMA_W + 1)'(ema_reg) + AVG_HALF;

    assign div_start = (state_reg == S_DIV_GO);
    assign div_numer = (DIV_W'(seed_sum_reg) <<< (FRAC_W + 1)) + DIV_W'(seed_cnt_reg);
    assign div_denom = {seed_cnt_reg, 1'b0};

    zlema_seed_div u_seed_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .numer    (div_numer),
        .denom    (div_denom),
        .done     (div_done),
        .quotient (div_quot)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            period_reg   <= PERIOD_RESET;
            alpha_reg    <= ALPHA_RESET;
            cnt_reg      <= '0;
            wp_reg       <= '0;
            seed_sum_reg <= '0;
            seed_cnt_reg <= '0;
            ema_def_reg  <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            // S_OUT handles the output register itself
            if (m_valid_reg && m_ready && state_reg != S_OUT) begin
                m_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE: begin
                    if (s_valid) begin
                        x_reg     <= s_sample;
                        xv_reg    <= s_sample_valid;
                        state_reg <= S_READ;
                    end
                end
                S_READ: begin
                    z_reg     <= z_calc;
                    zv_reg    <= zv_calc;
                    wp_reg    <= (wp_reg == ADDR_W'(DELAY_DEPTH - 1)) ? '0 : wp_reg + 1'b1;
                    state_reg <= S_EVAL;
                end
                S_EVAL: begin
                    prod_reg   <= mul_out;
                    cnt_reg    <= cnt_inc;
                    avg_ok_reg <= 1'b0;
                    state_reg  <= S_OUT;
                    if (cnt_reg < seed_at) begin
                        if (cnt_reg >= lag_8 && zv_reg) begin
                            seed_sum_reg <= sum_after;
                            seed_cnt_reg <= cnt_after;
                        end
                    end else if (cnt_reg == seed_at) begin
                        seed_sum_reg <= sum_after;
                        seed_cnt_reg <= cnt_after;
                        if (cnt_after != '0) begin
                            state_reg <= S_DIV_GO;
                        end
                    end else if (zv_reg && ema_def_reg) begin
                        state_reg <= S_MUL_BHI;
                    end
                end
                S_DIV_GO: begin
                    state_reg <= S_DIV_WAIT;
                end
                S_DIV_WAIT: begin
                    if (div_done) begin
                        ema_reg     <= div_quot;
                        ema_def_reg <= 1'b1;
                        avg_ok_reg  <= 1'b1;
                        state_reg   <= S_OUT;
                    end
                end
                S_MUL_BHI: begin
                    acc_reg   <= prod_reg;
                    prod_reg  <= mul_out;
                    state_reg <= S_MUL_BLO;
                end
                S_MUL_BLO: begin
                    acc_reg   <= acc_reg + prod_reg;
                    prod_reg  <= mul_out;
                    state_reg <= S_UPDATE;
                end
                S_UPDATE: begin
                    ema_reg    <= acc_upd[EMA_W-1:0];
                    avg_ok_reg <= 1'b1;
                    state_reg  <= S_OUT;
                end
                S_OUT: begin
                    // hold until the output register is free
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg         <= 1'b1;
                        m_average_valid_reg <= avg_ok_reg;
                        m_average_reg       <= avg_ok_reg ? avg_sum[EMA_W-1:FRAC_W] : '0;
                        state_reg           <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase

            if (cfg_we) begin
                unique case (cfg_index)
                    CFG_PERIOD: begin
                        period_reg   <= cfg_wdata[PERIOD_W-1:0];
                        cnt_reg      <= '0;
                        wp_reg       <= '0;
                        seed_sum_reg <= '0;
                        seed_cnt_reg <= '0;
                        ema_def_reg  <= 1'b0;
                    end
                    CFG_ALPHA: begin
                        alpha_reg <= cfg_wdata[ALPHA_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    assign s_ready         = (state_reg == S_IDLE);
    assign m_valid         = m_valid_reg;
    assign m_average       = m_average_reg;
    assign m_average_valid = m_average_valid_reg;

    `ZLEMA_ASSERT_NXT(a_accept_reads, aclk, aresetn, s_valid && s_ready, state_reg == S_READ)
    `ZLEMA_ASSERT_IMP(a_invalid_zero, aclk, aresetn, m_valid && !m_average_valid, m_average == '0)
    `ZLEMA_ASSERT_IMP(a_div_done_wait, aclk, aresetn, div_done, state_reg == S_DIV_WAIT)
    `ZLEMA_ASSERT_IMP(a_ema_clear_cfg, aclk, aresetn, $fell(ema_def_reg), !$past(aresetn) || $past(cfg_we && cfg_index == CFG_PERIOD))

endmodule

@@ sv/zlema_delay_mem.sv @@
module zlema_delay_mem
    import zlema_pkg::*;
#(
    parameter int DEPTH = DEF_DELAY_DEPTH
) (
    input  logic                                    aclk,
    input  logic                                    wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [MEM_W-1:0]                        wr_data,
    input  logic                                    rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [MEM_W-1:0]                        rd_data
);

    logic [MEM_W-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

@@ sv/zlema_seed_div.sv @@
module zlema_seed_div
    import zlema_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     start,
    input  logic signed [DIV_W-1:0]  numer,
    input  logic [DIVISOR_W-1:0]     denom,
    output logic                     done,
    output logic signed [EMA_W-1:0]  quotient
);

    localparam int STEP_W = $clog2(DIV_W);

    typedef enum logic [1:0] {D_IDLE, D_RUN, D_FIX} div_state_t;

    div_state_t              state_reg;
    logic [DIV_W-1:0]        mag_reg;
    logic [DIV_W-1:0]        quo_reg;
    logic [DIVISOR_W-1:0]    den_reg;
    logic [DIVISOR_W-1:0]    rem_reg;
    logic                    neg_reg;
    logic [STEP_W-1:0]       step_reg;
    logic                    done_reg;
    logic signed [EMA_W-1:0] quo_out_reg;

    logic [DIVISOR_W:0]      trial;
    logic [DIVISOR_W:0]      trial_sub;
    logic                    fits;
    logic [DIV_W-1:0]        numer_mag;
    logic [DIV_W-1:0]        quo_signed;

    assign numer_mag = numer[DIV_W-1] ? DIV_W'(-numer) : DIV_W'(numer);
    assign trial     = {rem_reg, mag_reg[DIV_W-1]};
    assign fits      = trial >= {1'b0, den_reg};
    assign trial_sub = trial - {1'b0, den_reg};

    // floor for a negative numerator: -(q+1) when a remainder is left
    assign quo_signed = !neg_reg ? quo_reg :
                        (rem_reg != '0) ? ~quo_reg : (~quo_reg + 1'b1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= D_IDLE;
            done_reg  <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            unique case (state_reg)
                D_IDLE: begin
                    if (start) begin
                        mag_reg   <= numer_mag;
                        neg_reg   <= numer[DIV_W-1];
                        den_reg   <= denom;
                        rem_reg   <= '0;
                        quo_reg   <= '0;
                        step_reg  <= '0;
                        state_reg <= D_RUN;
                    end
                end
                D_RUN: begin
                    rem_reg  <= fits ? trial_sub[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
                    quo_reg  <= {quo_reg[DIV_W-2:0], fits};
                    mag_reg  <= {mag_reg[DIV_W-2:0], 1'b0};
                    step_reg <= step_reg + 1'b1;
                    if (step_reg == STEP_W'(DIV_W - 1)) begin
                        state_reg <= D_FIX;
                    end
                end
                D_FIX: begin
                    quo_out_reg <= EMA_W'(quo_signed);
                    done_reg    <= 1'b1;
                    state_reg   <= D_IDLE;
                end
                default: state_reg <= D_IDLE;
            endcase
        end
    end

    assign done     = done_reg;
    assign quotient = quo_out_reg;

endmodule

@@ sim/tb_zero_lag_ema_filter_core.sv @@
`timescale 1ns / 1ps

module tb_zero_lag_ema_filter_core;
    import zlema_pkg::*;

    localparam int     ITEM_TARGET = 1900;
    localparam int     HOLD_CYCLES = 250;
    localparam int     CYCLE_LIMIT = 1_000_000;
    localparam longint Q_UNIT      = 65536;

    // indexes with no register behind them
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;

    localparam logic signed [SAMPLE_W-1:0] SMP_MAX = 32'sh7fff_ffff;
    localparam logic signed [SAMPLE_W-1:0] SMP_MIN = 32'sh8000_0000;

    typedef struct {
        logic signed [AVG_W-1:0] avg;
        logic                    ok;
    } ema_result_t;

    class ema_scoreboard;
        logic [PERIOD_W-1:0] period_reg;
        logic [ALPHA_W-1:0]  alpha_reg;
        longint              taps[DEF_DELAY_DEPTH];
        bit                  tap_ok[DEF_DELAY_DEPTH];
        int unsigned         seen;
        longint              seed_sum;
        int unsigned         seed_cnt;
        longint              ema;
        bit                  ema_live;
        ema_result_t         due_results[$];
        int unsigned         errors;
        int unsigned         checked;

        function new();
            period_reg = PERIOD_RESET;
            alpha_reg  = ALPHA_RESET;
            errors     = 0;
            checked    = 0;
            clear();
        endfunction

        function void clear();
            foreach (taps[k]) begin
                taps[k]   = 0;
                tap_ok[k] = 1'b0;
            end
            seen     = 0;
            seed_sum = 0;
            seed_cnt = 0;
            ema      = 0;
            ema_live = 1'b0;
        endfunction

        function int pending_count();
            return due_results.size();
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            if (idx == CFG_PERIOD) begin
                period_reg = data[PERIOD_W-1:0];
                clear();
            end else if (idx == CFG_ALPHA) begin
                alpha_reg = data[ALPHA_W-1:0];
            end
        endfunction

        // floor division, d > 0
        function longint floor_quot(longint n, longint d);
            longint q;
            q = n / d;
            if ((n % d) != 0 && n < 0)
                q--;
            return q;
        endfunction

        function void note_sample(logic signed [SAMPLE_W-1:0] smp, logic pres);
            int unsigned p, lag, seed_at;
            longint      a, b, x, z, lo, hi, c, q;
            bit          zv, ov;
            ema_result_t res;
            p = period_reg;
            if (p < 1)
                p = 1;
            if (p > DEF_MAX_PERIOD)
                p = DEF_MAX_PERIOD;
            lag = (p - 1) / 2;
            if (lag > DEF_DELAY_DEPTH)
                lag = DEF_DELAY_DEPTH;
            seed_at = p + lag - 1;
            a = (alpha_reg > Q_ONE) ? Q_ONE : alpha_reg;
            x = smp;
            z = 0;
            ov = 1'b0;
            if (lag == 0) begin
                zv = pres;
                z  = x;
            end else begin
                zv = pres && tap_ok[lag-1];
                if (zv)
                    z = 2 * x - taps[lag-1];
            end

            if (seen < seed_at) begin
                if (seen >= lag && zv) begin
                    seed_sum += z;
                    seed_cnt++;
                end
            end else if (seen == seed_at) begin
                if (zv) begin
                    seed_sum += z;
                    seed_cnt++;
                end
                // an empty seed window leaves the average undefined until cleared
                if (seed_cnt > 0) begin
                    c        = seed_cnt;
                    ema      = floor_quot(seed_sum * 2 * Q_UNIT + c, 2 * c);
                    ema_live = 1'b1;
                    ov       = 1'b1;
                end
            end else if (zv && ema_live) begin
                b   = Q_UNIT - a;
                lo  = ema & 64'hffff;
                hi  = (ema - lo) / Q_UNIT;
                ema = a * z + b * hi + ((b * lo + Q_HALF) >>> 16);
                ov  = 1'b1;
            end

            res.ok  = ov;
            res.avg = '0;
            if (ov) begin
                q       = floor_quot(ema + Q_HALF, Q_UNIT);
                res.avg = q[AVG_W-1:0];
            end
            due_results.insert(due_results.size(), res);

            for (int k = DEF_DELAY_DEPTH - 1; k > 0; k--) begin
                taps[k]   = taps[k-1];
                tap_ok[k] = tap_ok[k-1];
            end
            taps[0]   = x;
            tap_ok[0] = pres;
            if (seen < CNT_MAX)
                seen++;
        endfunction

        task report(input string msg);
            errors++;
            if (errors <= 50)
                $display("%0t: mismatch: %s", $time, msg);
        endtask

        task check_result(input logic signed [AVG_W-1:0] avg, input logic ok);
            ema_result_t want;
            checked++;
            if (due_results.size() == 0) begin
                report($sformatf("unexpected word average=%0d valid=%0b", avg, ok));
                return;
            end
            want = due_results.pop_front();
            if (ok !== want.ok)
                report($sformatf("word %0d: average_valid %0b, want %0b",
                                 checked, ok, want.ok));
            if (avg !== want.avg)
                report($sformatf("word %0d: average %0d, want %0d",
                                 checked, avg, want.avg));
        endtask
    endclass

    logic                       aclk;
    logic                       aresetn;
    logic                       s_valid;
    logic                       s_ready;
    logic signed [SAMPLE_W-1:0] s_sample;
    logic                       s_sample_valid;
    logic                       m_valid;
    logic                       m_ready;
    logic signed [AVG_W-1:0]    m_average;
    logic                       m_average_valid;
    logic                       cfg_we;
    logic [CFG_IDX_W-1:0]       cfg_index;
    logic [CFG_DATA_W-1:0]      cfg_wdata;

    ema_scoreboard scb = new();
    bit            sender_burst;
    int unsigned   cycle_count;

    zero_lag_ema_filter_core i_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_sample        (s_sample),
        .s_sample_valid  (s_sample_valid),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_average       (m_average),
        .m_average_valid (m_average_valid),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    initial begin
        cycle_count = 0;
        forever begin
            @(posedge aclk);
            cycle_count++;
            if (cycle_count >= CYCLE_LIMIT) begin
                $display("tb_zero_lag_ema_filter_core: errors");
                $finish;
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            scb.check_result(m_average, m_average_valid);
    end

    function automatic int unsigned sender_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] pick_sample();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 8)
            return SMP_MAX;
        if (r < 16)
            return SMP_MIN;
        if (r < 24)
            return $signed($urandom_range(0, 6)) - 3;
        if (r < 60)
            return $signed($urandom_range(0, 2000)) - 1000;
        return $urandom;
    endfunction

    // entered and left at a falling edge
    task automatic push_sample(input logic signed [SAMPLE_W-1:0] smp, input logic pres);
        int unsigned gap;
        gap = sender_burst ? 0 : sender_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid        <= 1'b1;
        s_sample       <= smp;
        s_sample_valid <= pres;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        scb.note_sample(smp, pres);
        @(negedge aclk);
    endtask

    // drain the core, then write one register
    task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        s_valid <= 1'b0;
        while (scb.pending_count() != 0)
            @(negedge aclk);
        repeat (2) @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        scb.write_reg(idx, data);
        @(negedge aclk);
        cfg_we <= 1'b0;
    endtask

    initial begin : result_sink
        int unsigned run_left;
        int unsigned hold_left;
        int unsigned r;
        bit          stalling;
        bit          held;
        run_left  = 0;
        hold_left = 0;
        stalling  = 1'b0;
        held      = 1'b0;
        m_ready   = 1'b0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (!held && scb.checked >= 400) begin
                // long hold-off: the core must fill up and stall its input
                held      = 1'b1;
                hold_left = HOLD_CYCLES - 1;
                m_ready   <= 1'b0;
            end else begin
                if (run_left == 0) begin
                    r = $urandom_range(0, 99);
                    stalling = (r >= 50);
                    if (r < 40)
                        run_left = $urandom_range(1, 20);
                    else if (r < 50)
                        run_left = $urandom_range(50, 150);
                    else if (r < 85)
                        run_left = $urandom_range(1, 3);
                    else if (r < 97)
                        run_left = $urandom_range(4, 10);
                    else
                        run_left = $urandom_range(20, 40);
                end
                run_left--;
                m_ready <= !stalling;
            end
        end
    end

    initial begin : stimulus
        int unsigned total, n_items, phase_no, r, per, eff, lag, nan_pct;
        logic [ALPHA_W-1:0] alpha;
        aresetn        = 1'b0;
        s_valid        = 1'b0;
        s_sample       = '0;
        s_sample_valid = 1'b0;
        cfg_we         = 1'b0;
        cfg_index      = CFG_PERIOD;
        cfg_wdata      = '0;
        sender_burst   = 1'b0;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // period zero acts as one (no lag, seed on the first word); alpha above one saturates
        set_reg(CFG_PERIOD, '0);
        set_reg(CFG_ALPHA, 17'h1ffff);
        push_sample(SMP_MAX, 1'b1);
        push_sample(SMP_MIN, 1'b1);
        push_sample('0, 1'b0);
        push_sample(-32'sd1, 1'b1);
        push_sample(SMP_MAX, 1'b1);

        // alpha write keeps the average; zero alpha freezes it
        set_reg(CFG_ALPHA, '0);
        push_sample(SMP_MIN, 1'b1);
        push_sample(32'sd123, 1'b1);

        // writes to unused indexes change nothing
        set_reg(CFG_SPARE_LO, 17'h1ffff);
        set_reg(CFG_SPARE_HI, 17'h1ffff);
        push_sample(32'sd5, 1'b1);

        // seed window with no present value: average stays undefined
        set_reg(CFG_PERIOD, 17'd3);
        set_reg(CFG_ALPHA, Q_ONE);
        repeat (4) push_sample(SMP_MAX, 1'b0);
        push_sample(32'sd7, 1'b1);
        push_sample(32'sd8, 1'b1);

        // zero lag, then a missing sample after seeding
        set_reg(CFG_PERIOD, 17'd2);
        set_reg(CFG_ALPHA, 17'd32768);
        push_sample(SMP_MAX, 1'b1);
        push_sample(SMP_MAX, 1'b1);
        push_sample(SMP_MIN, 1'b1);
        push_sample(SMP_MIN, 1'b0);
        push_sample(SMP_MIN, 1'b1);

        // de-lagged value at both extremes
        set_reg(CFG_PERIOD, 17'd3);
        set_reg(CFG_ALPHA, 17'd40000);
        push_sample(SMP_MAX, 1'b1);
        push_sample(SMP_MIN, 1'b1);
        push_sample(SMP_MAX, 1'b1);
        push_sample(SMP_MIN, 1'b1);
        push_sample(SMP_MAX, 1'b1);

        total    = 0;
        phase_no = 0;
        while (total < ITEM_TARGET) begin
            case (phase_no)
                0: per = 100;
                1: per = 64;
                default: begin
                    r = $urandom_range(0, 99);
                    if (r < 60)
                        per = $urandom_range(1, 12);
                    else if (r < 80)
                        per = $urandom_range(13, 40);
                    else if (r < 90)
                        per = $urandom_range(41, 64);
                    else if (r < 95)
                        per = 0;
                    else
                        per = $urandom_range(65, 127);
                end
            endcase
            set_reg(CFG_PERIOD, {10'($urandom_range(0, 1023)), per[PERIOD_W-1:0]});

            r = $urandom_range(0, 99);
            if (r < 10)
                alpha = '0;
            else if (r < 20)
                alpha = Q_ONE;
            else if (r < 28)
                alpha = ALPHA_W'($urandom_range(65537, 131071));
            else
                alpha = ALPHA_W'($urandom_range(1, 65535));
            set_reg(CFG_ALPHA, alpha);

            eff = (per == 0) ? 1 : (per > DEF_MAX_PERIOD ? DEF_MAX_PERIOD : per);
            lag = (eff - 1) / 2;
            n_items = eff + lag + $urandom_range(10, 60);

            r = $urandom_range(0, 99);
            nan_pct = (r < 75) ? 5 : (r < 90 ? 40 : 85);
            sender_burst = ($urandom_range(0, 3) == 0);

            for (int i = 0; i < n_items; i++) begin
                if (i == n_items / 2) begin
                    r = $urandom_range(0, 9);
                    if (r < 2)
                        set_reg(CFG_ALPHA, CFG_DATA_W'($urandom_range(0, 131071)));
                    else if (r == 2)
                        set_reg($urandom_range(0, 1) ? CFG_SPARE_LO : CFG_SPARE_HI,
                                CFG_DATA_W'($urandom_range(0, 131071)));
                end
                push_sample(pick_sample(), $urandom_range(0, 99) >= nan_pct);
            end
            total += n_items;
            phase_no++;
        end

        s_valid <= 1'b0;
        while (scb.pending_count() != 0)
            @(negedge aclk);
        repeat (20) @(negedge aclk);
        if (scb.errors == 0)
            $display("tb_zero_lag_ema_filter_core: clean");
        else
            $display("tb_zero_lag_ema_filter_core: errors");
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+sv
sv/zlema_pkg.sv
sv/zlema_delay_mem.sv
sv/zlema_seed_div.sv
sv/zero_lag_ema_filter_core.sv
sim/tb_zero_lag_ema_filter_core.sv
